>>> hdl/assert_macros.svh
// Assertion helpers for the RTL; olst_back is the only file that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)

`endif

`endif

>>> hdl/olst_pkg.sv
package olst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DATA_W       = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_ADD_EMPTY  = 3'd1,
        CMD_ADD_FRONT  = 3'd2,
        CMD_ADD_BACK   = 3'd3,
        CMD_INS_AFTER  = 3'd4,
        CMD_INS_BEFORE = 3'd5,
        CMD_DELETE     = 3'd6,
        CMD_READ_ALL   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_CLEAR,
        K_ADD_EMPTY,
        K_ADD_FRONT,
        K_ADD_BACK,
        K_INS_AFTER,
        K_INS_BEFORE,
        K_DELETE,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] value_out;
        logic                     last_of_run;
    } t_out_item;

    // decoded request: val is stored or returned, key is what the search matches
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] key;
    } t_op;

endpackage

>>> hdl/olst_front.sv
module olst_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  olst_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    output logic               o_push,
    output olst_pkg::t_op      o_push_op,
    input  logic               i_q_full
);

    olst_pkg::t_kind w_kind;
    logic            r_seen;

    always_comb begin
        unique case (i_in_item.command)
            olst_pkg::CMD_CLEAR:      w_kind = olst_pkg::K_CLEAR;
            olst_pkg::CMD_ADD_EMPTY:  w_kind = olst_pkg::K_ADD_EMPTY;
            olst_pkg::CMD_ADD_FRONT:  w_kind = olst_pkg::K_ADD_FRONT;
            olst_pkg::CMD_ADD_BACK:   w_kind = olst_pkg::K_ADD_BACK;
            olst_pkg::CMD_INS_AFTER:  w_kind = olst_pkg::K_INS_AFTER;
            olst_pkg::CMD_INS_BEFORE: w_kind = olst_pkg::K_INS_BEFORE;
            olst_pkg::CMD_DELETE:     w_kind = olst_pkg::K_DELETE;
            default:                  w_kind = olst_pkg::K_READ;
        endcase
    end

    // delete matches on its own value
    always_comb begin
        o_push_op.kind = w_kind;
        o_push_op.val  = i_in_item.value;
        o_push_op.key  = (w_kind == olst_pkg::K_DELETE) ? i_in_item.value : i_in_item.key;
    end

    // no transfer is taken in the first cycle out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= 1'b1;
        end
    end

    assign o_in_stall = i_q_full || !r_seen;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

>>> hdl/olst_queue.sv
module olst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  olst_pkg::t_op i_push_op,
    output logic          o_full,
    output logic          o_valid,
    output olst_pkg::t_op o_op,
    input  logic          i_pop
);

    localparam int QD  = olst_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    olst_pkg::t_op  r_slot [QD];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_level;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_level == QCW'(QD));
    assign o_valid = (r_level != '0);
    assign o_op    = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QAW'(QD - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(QD - 1)) ? '0 : r_rd + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + QCW'(1);
            end else if (w_pop && !w_push) begin
                r_level <= r_level - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_push_op;
        end
    end

endmodule

>>> hdl/olst_back.sv
`include "assert_macros.svh"

module olst_back #(
    parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  olst_pkg::t_op       i_op,
    output logic                o_pop,
    output logic                o_out_valid,
    output olst_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = olst_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_READ,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_pos, n_pos;
    olst_pkg::t_kind     r_kind, n_kind;
    logic [DW-1:0]       r_val, n_val;
    logic [DW-1:0]       r_key, n_key;
    olst_pkg::t_status   r_res_status, n_res_status;
    logic [DW-1:0]       r_res_val, n_res_val;
    logic                r_out_valid, n_out_valid;
    olst_pkg::t_out_item r_out, n_out;

    logic [DW-1:0] r_mem [CAPACITY];
    logic [DW-1:0] r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;

    logic          w_out_free;
    logic          w_empty;
    logic          w_full;
    logic          w_at_end;
    logic          w_hit;
    logic [AW-1:0] w_cnt_a;
    logic [AW-1:0] w_cnt_m1;

    function automatic olst_pkg::t_out_item mk_out(olst_pkg::t_status s, logic [DW-1:0] v,
                                                   logic l);
        olst_pkg::t_out_item o;
        o.status      = s;
        o.value_out   = v;
        o.last_of_run = l;
        return o;
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_cnt_a    = r_count[AW-1:0];
    assign w_cnt_m1   = AW'(r_count - CW'(1));
    assign w_at_end   = (r_addr == w_cnt_m1);
    assign w_hit      = (r_rdata == r_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_pos        = r_pos;
        n_kind       = r_kind;
        n_val        = r_val;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_out_valid  = w_out_free ? 1'b0 : r_out_valid;
        n_out        = r_out;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = r_val;
        o_pop        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_pop       = 1'b1;
                    n_kind      = i_op.kind;
                    n_val       = i_op.val;
                    n_key       = i_op.key;
                    n_addr      = '0;
                    n_out_valid = 1'b1;
                    n_out       = mk_out(olst_pkg::ST_OK, '0, 1'b1);
                    unique case (i_op.kind) inside
                        olst_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        olst_pkg::K_ADD_EMPTY: begin
                            if (!w_empty) begin
                                n_out = mk_out(olst_pkg::ST_NOT_EMPTY, '0, 1'b1);
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = i_op.val;
                                n_count = CW'(1);
                            end
                        end
                        olst_pkg::K_ADD_FRONT, olst_pkg::K_ADD_BACK: begin
                            if (w_full) begin
                                n_out = mk_out(olst_pkg::ST_FULL, '0, 1'b1);
                            end else if (w_empty || i_op.kind == olst_pkg::K_ADD_BACK) begin
                                w_we    = 1'b1;
                                w_waddr = w_cnt_a;
                                w_wdata = i_op.val;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_pos       = '0;
                                n_addr      = w_cnt_m1;
                                n_state     = S_SHIFT_UP;
                            end
                        end
                        olst_pkg::K_INS_AFTER, olst_pkg::K_INS_BEFORE: begin
                            if (w_empty) begin
                                n_out = mk_out(olst_pkg::ST_EMPTY, '0, 1'b1);
                            end else if (w_full) begin
                                n_out = mk_out(olst_pkg::ST_FULL, '0, 1'b1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SEARCH;
                            end
                        end
                        olst_pkg::K_DELETE: begin
                            if (w_empty) begin
                                n_out = mk_out(olst_pkg::ST_EMPTY, '0, 1'b1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_SEARCH;
                            end
                        end
                        olst_pkg::K_READ: begin
                            if (w_empty) begin
                                n_out = mk_out(olst_pkg::ST_EMPTY, '0, 1'b1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_res_status = olst_pkg::ST_OK;
                    if (r_kind == olst_pkg::K_DELETE) begin
                        n_res_val = r_rdata;
                        if (w_at_end) begin
                            n_count = r_count - CW'(1);
                            n_state = S_FINISH;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_state = S_SHIFT_DN;
                        end
                    end else begin
                        n_res_val = '0;
                        if (r_kind == olst_pkg::K_INS_AFTER && w_at_end) begin
                            w_we    = 1'b1;
                            w_waddr = w_cnt_a;
                            w_wdata = r_val;
                            n_count = r_count + CW'(1);
                            n_state = S_FINISH;
                        end else begin
                            n_pos   = (r_kind == olst_pkg::K_INS_AFTER) ? r_addr + AW'(1) : r_addr;
                            n_addr  = w_cnt_m1;
                            n_state = S_SHIFT_UP;
                        end
                    end
                end else if (w_at_end) begin
                    n_res_status = olst_pkg::ST_NOT_FOUND;
                    n_res_val    = '0;
                    n_state      = S_FINISH;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SHIFT_UP: begin
                w_we    = 1'b1;
                w_waddr = r_addr + AW'(1);
                w_wdata = r_rdata;
                if (r_addr == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            S_PUT: begin
                w_we         = 1'b1;
                w_waddr      = r_pos;
                w_wdata      = r_val;
                n_count      = r_count + CW'(1);
                n_res_status = olst_pkg::ST_OK;
                n_res_val    = '0;
                n_state      = S_FINISH;
            end
            S_SHIFT_DN: begin
                w_we    = 1'b1;
                w_waddr = r_addr - AW'(1);
                w_wdata = r_rdata;
                if (w_at_end) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FINISH;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_out(olst_pkg::ST_OK, r_rdata, w_at_end);
                    if (w_at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_out(r_res_status, r_res_val, 1'b1);
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_addr       <= n_addr;
            r_pos        <= n_pos;
            r_kind       <= n_kind;
            r_val        <= n_val;
            r_key        <= n_key;
            r_res_status <= n_res_status;
            r_res_val    <= n_res_val;
            r_out        <= n_out;
        end
    end

    // read port follows the next address, so r_rdata holds r_mem[r_addr] as it was before any write in the same cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `ASSERT_IMPLY(a_read_range, i_clk, i_rst_n, r_state == S_READ, CW'(r_addr) < r_count, "read past end")
    `ASSERT_IMPLY(a_shift_room, i_clk, i_rst_n, r_state == S_SHIFT_UP, !w_full, "shift on full list")
    `ASSERT_IMPLY(a_count_step, i_clk, i_rst_n, r_count != $past(r_count), r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1) || r_count == '0, "count jumped")

endmodule

>>> hdl/ordered_list_engine_unit.sv
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, kept in one
// entry memory with one read port and one write port. Requests enter through a two-deep
// queue, so a new request is taken while the engine is busy and the queue has room. Clear,
// add to empty, add at the back and every refused request finish in the idle state. Insert
// and delete search from the front one entry a cycle and then shift the tail one entry a
// cycle, a pace set by the one read and one write per cycle of the entry memory. Read out
// gives one transfer per entry per cycle while the output is not stalled, the last marked
// by last_of_run. Each request ends in exactly one transfer with last_of_run set.
module ordered_list_engine_unit #(
    parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  olst_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output olst_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    logic          w_push;
    olst_pkg::t_op w_push_op;
    logic          w_q_full;
    logic          w_q_valid;
    olst_pkg::t_op w_q_op;
    logic          w_pop;

    olst_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_push_op  (w_push_op),
        .i_q_full   (w_q_full)
    );

    olst_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .o_full    (w_q_full),
        .o_valid   (w_q_valid),
        .o_op      (w_q_op),
        .i_pop     (w_pop)
    );

    olst_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_op        (w_q_op),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
